// File: rtl/swfe_pkg.sv
// ----------------------------------------------------------------------------
// swfe_pkg
// Shared types and constants for the sync word frame extractor: the sync
// byte values, the queue geometry and the operation record that the front
// end hands to the back end.
// ----------------------------------------------------------------------------
package swfe_pkg;

	localparam int          CFG_W           = 13;
	localparam logic [12:0] FRAME_LEN_RESET = 13'd64;
	localparam logic [12:0] FRAME_LEN_MIN   = 13'd3;

	localparam logic [7:0]  SYNC_HI  = 8'hFF;
	localparam logic [7:0]  SYNC_MID = 8'h0F;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	// A pass operation emits one byte; a sync operation emits the three sync bytes.
	typedef enum logic {
		OP_PASS = 1'b0,
		OP_SYNC = 1'b1
	} op_kind_t;

	typedef struct packed {
		op_kind_t    kind;
		logic [7:0]  data;
		logic        last;
		logic        trunc;
	} op_t;

	// Position within the three-byte sync burst on the output side.
	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_MID  = 2'd1,
		PH_HI   = 2'd2
	} sync_phase_t;

endpackage

// File: rtl/swfe_front.sv
// ----------------------------------------------------------------------------
// swfe_front
// Input side: holds the frame length register, hunts for the sync word and
// tracks the open frame, and turns each byte into at most one operation.
// ----------------------------------------------------------------------------
module swfe_front #(
	parameter int MAX_FRAME = 4096
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	input  logic [7:0]          s_axis_tdata,
	input  logic                s_axis_tlast,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [12:0]         cfg_data,
	input  logic                q_full,
	output logic                q_push,
	output swfe_pkg::op_t       q_op
);
	import swfe_pkg::*;

	localparam int LEFT_W = (MAX_FRAME > 4) ? $clog2(MAX_FRAME) : 2;

	// Bytes owed after the sync word, for a given raw length register value.
	function automatic logic [LEFT_W-1:0] owed_after_sync(input logic [CFG_W-1:0] len);
		logic [LEFT_W-1:0] res;
		if (len < FRAME_LEN_MIN) begin
			res = '0;
		end else if (32'(len) > MAX_FRAME) begin
			res = LEFT_W'(MAX_FRAME - 3);
		end else begin
			res = LEFT_W'(32'(len) - 32'd3);
		end
		return res;
	endfunction

	logic [LEFT_W-1:0] owed_q;
	logic              in_frame_q;
	logic [15:0]       recent_q;
	logic [1:0]        recent_cnt_q;
	logic [LEFT_W-1:0] left_q;

	logic              accept;
	logic              match;
	logic [LEFT_W-1:0] left_dec;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = !q_full;
	assign accept        = s_axis_tvalid && s_axis_tready;

	assign match    = !in_frame_q && (recent_cnt_q == 2'd2)
	                  && (recent_q == {SYNC_HI, SYNC_MID}) && (s_axis_tdata == SYNC_HI);
	assign left_dec = (left_q != '0) ? left_q - LEFT_W'(1) : left_q;

	always_comb begin
		q_push   = accept && (in_frame_q || match);
		q_op     = '0;
		q_op.data = s_axis_tdata;
		if (in_frame_q) begin
			q_op.kind = OP_PASS;
			if (left_dec == '0) begin
				q_op.last = 1'b1;
			end else if (s_axis_tlast) begin
				q_op.last  = 1'b1;
				q_op.trunc = 1'b1;
			end
		end else begin
			q_op.kind = OP_SYNC;
			if (owed_q == '0) begin
				q_op.last = 1'b1;
			end else if (s_axis_tlast) begin
				q_op.last  = 1'b1;
				q_op.trunc = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owed_q <= owed_after_sync(FRAME_LEN_RESET);
		end else if (cfg_valid && cfg_ready) begin
			owed_q <= owed_after_sync(cfg_data);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q   <= 1'b0;
			recent_q     <= '0;
			recent_cnt_q <= '0;
			left_q       <= '0;
		end else if (accept) begin
			if (in_frame_q) begin
				recent_q     <= '0;
				recent_cnt_q <= '0;
				if (left_dec == '0 || s_axis_tlast) begin
					in_frame_q <= 1'b0;
					left_q     <= '0;
				end else begin
					left_q <= left_dec;
				end
			end else if (match) begin
				recent_q     <= '0;
				recent_cnt_q <= '0;
				if (owed_q != '0 && !s_axis_tlast) begin
					in_frame_q <= 1'b1;
					left_q     <= owed_q;
				end
			end else if (s_axis_tlast) begin
				recent_q     <= '0;
				recent_cnt_q <= '0;
			end else begin
				recent_q <= {recent_q[7:0], s_axis_tdata};
				if (recent_cnt_q != 2'd2) begin
					recent_cnt_q <= recent_cnt_q + 2'd1;
				end
			end
		end
	end

endmodule

// File: rtl/swfe_queue.sv
// ----------------------------------------------------------------------------
// swfe_queue
// Small first-in first-out buffer of operations between the front end and
// the back end, so that either side can stall without stopping the other.
// ----------------------------------------------------------------------------
module swfe_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  swfe_pkg::op_t push_op,
	output logic          full,
	input  logic          pop,
	output logic          empty,
	output swfe_pkg::op_t head_op
);
	import swfe_pkg::*;

	op_t               mem [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	assign full    = (count_q == (QPTR_W + 1)'(QUEUE_DEPTH));
	assign empty   = (count_q == '0);
	assign head_op = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + (QPTR_W + 1)'(1);
				2'b01:   count_q <= count_q - (QPTR_W + 1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: rtl/swfe_back.sv
// ----------------------------------------------------------------------------
// swfe_back
// Output side: takes operations from the queue and drives the output
// register, expanding a sync operation into its three bytes.
// ----------------------------------------------------------------------------
module swfe_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_empty,
	input  swfe_pkg::op_t q_head,
	output logic          q_pop,
	output logic          m_axis_tvalid,
	input  logic          m_axis_tready,
	output logic [7:0]    m_axis_tdata,
	output logic [1:0]    m_axis_tuser,
	output logic          m_axis_tlast
);
	import swfe_pkg::*;

	sync_phase_t phase_q;
	sync_phase_t phase_d;
	logic        out_valid_q;
	logic [7:0]  out_data_q;
	logic        out_start_q;
	logic        out_last_q;
	logic        out_trunc_q;
	logic        sync_last_q;
	logic        sync_trunc_q;
	logic        advance;

	// The output register may be reloaded when it is empty or its transfer completes.
	assign advance = !out_valid_q || m_axis_tready;
	assign q_pop   = advance && (phase_q == PH_IDLE) && !q_empty;

	always_comb begin
		phase_d = phase_q;
		if (advance) begin
			case (phase_q)
				PH_MID:  phase_d = PH_HI;
				PH_HI:   phase_d = PH_IDLE;
				PH_IDLE: phase_d = (q_pop && q_head.kind == OP_SYNC) ? PH_MID : PH_IDLE;
				default: phase_d = PH_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			phase_q <= phase_d;
			if (advance) begin
				out_valid_q <= (phase_q != PH_IDLE) || !q_empty;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			case (phase_q)
				PH_MID: begin
					out_data_q  <= SYNC_MID;
					out_start_q <= 1'b0;
					out_last_q  <= 1'b0;
					out_trunc_q <= 1'b0;
				end
				PH_HI: begin
					out_data_q  <= SYNC_HI;
					out_start_q <= 1'b0;
					out_last_q  <= sync_last_q;
					out_trunc_q <= sync_trunc_q;
				end
				default: begin
					if (q_head.kind == OP_SYNC) begin
						out_data_q  <= SYNC_HI;
						out_start_q <= 1'b1;
						out_last_q  <= 1'b0;
						out_trunc_q <= 1'b0;
					end else begin
						out_data_q  <= q_head.data;
						out_start_q <= 1'b0;
						out_last_q  <= q_head.last;
						out_trunc_q <= q_head.trunc;
					end
					sync_last_q  <= q_head.last;
					sync_trunc_q <= q_head.trunc;
				end
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = {out_trunc_q, out_start_q};
	assign m_axis_tlast  = out_last_q;

endmodule

// File: rtl/sync_word_frame_extractor_unit.sv
// ----------------------------------------------------------------------------
// sync_word_frame_extractor_unit
// Hunts for the sync word FF 0F FF within each datagram and forwards frames
// of the configured length, cutting a frame short at a datagram end.
// ----------------------------------------------------------------------------
// The block takes one input byte per cycle while the queue has room. A byte
// that falls inside a frame yields one output byte; the third byte of a sync
// word yields the three sync bytes, which leave one after another through
// the single output register. Bytes that are hunted without a match yield
// nothing. A four-entry operation queue sits between the input and output
// sides, so the input keeps flowing through a sync burst as long as the queue
// has room; sustained throughput is one output byte per cycle while the
// output is not stalled, set by the output register. The frame length
// register is clamped into the range three to MAX_FRAME; the user must write
// it only while no frame is in progress, which the block does not enforce.
// ----------------------------------------------------------------------------
module sync_word_frame_extractor_unit #(
	parameter int MAX_FRAME = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
	input  logic        s_axis_tlast,   // datagram_end
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,   // [7:0] frame_byte
	output logic [1:0]  m_axis_tuser,   // [0] frame_start, [1] truncated
	output logic        m_axis_tlast,   // frame_end
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [12:0] cfg_data        // frame_length
);
	import swfe_pkg::*;

	logic q_full;
	logic q_empty;
	logic q_push;
	logic q_pop;
	op_t  push_op;
	op_t  head_op;

	swfe_front #(
		.MAX_FRAME(MAX_FRAME)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tlast (s_axis_tlast),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_op         (push_op)
	);

	swfe_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.push_op(push_op),
		.full   (q_full),
		.pop    (q_pop),
		.empty  (q_empty),
		.head_op(head_op)
	);

	swfe_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_empty      (q_empty),
		.q_head       (head_op),
		.q_pop        (q_pop),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast)
	);

endmodule

// File: rtl/swfe_checker.sv
// ----------------------------------------------------------------------------
// swfe_checker
// Port-level checks on the output stream of the frame extractor, attached
// to the top level by a bind statement.
// ----------------------------------------------------------------------------
module swfe_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       m_axis_tvalid,
	input logic       m_axis_tready,
	input logic [7:0] m_axis_tdata,
	input logic [1:0] m_axis_tuser,
	input logic       m_axis_tlast
);
	import swfe_pkg::*;

	// A stalled output transfer keeps its contents.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid
		&& $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
		else $error("output changed while stalled");

	// A frame always opens with the first sync byte.
	a_start_byte: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == SYNC_HI)
		else $error("frame start on a byte other than the sync byte");

	// The first sync byte never closes a frame.
	a_start_not_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |-> !m_axis_tlast)
		else $error("frame start and frame end on the same byte");

	// Truncation is only reported on the closing byte of a frame.
	a_trunc_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tlast)
		else $error("truncated flag without frame end");

endmodule

bind sync_word_frame_extractor_unit swfe_checker u_swfe_checker (.*);

// File: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sync word frame extractor. Directed tests cover
// the length register at reset, below its minimum and above its maximum, a
// sync word closed by a datagram end, history cleared by a datagram end and
// sync words inside an open frame. Random datagrams rich in sync bytes then
// run under several idling patterns on both stream sides. A local model of
// the hunting and framing logic predicts every output transfer, and each
// transfer is checked in order against that prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;

	import swfe_pkg::*;

	localparam int MAX_FRAME    = 4096;
	localparam int DRAIN_CYCLES = 8;
	localparam int CYCLE_LIMIT  = 400000;

	typedef struct packed {
		logic [7:0] data;
		logic       start;
		logic       fend;
		logic       trunc;
	} frame_byte_t;

	logic        clk;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata  = 8'h00;
	logic        s_axis_tlast  = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [7:0]  m_axis_tdata;
	logic [1:0]  m_axis_tuser;
	logic        m_axis_tlast;
	logic        cfg_valid     = 1'b0;
	logic        cfg_ready;
	logic [12:0] cfg_data      = 13'd0;

	// Local copy of the extractor state.
	logic [CFG_W-1:0] fr_length;
	logic             fr_in_frame;
	logic [15:0]      fr_history;
	logic [1:0]       fr_history_cnt;
	logic [11:0]      fr_left;

	frame_byte_t pending_frame_bytes[$];
	frame_byte_t seen_byte;
	frame_byte_t want_byte;

	int errors         = 0;
	int cycle_count    = 0;
	int framed_items   = 0;
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;

	sync_word_frame_extractor_unit #(
		.MAX_FRAME(MAX_FRAME)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	always @(posedge clk)
		m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

	// Output checker: every transfer must match the oldest predicted byte.
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			seen_byte = '{data: m_axis_tdata, start: m_axis_tuser[0],
				fend: m_axis_tlast, trunc: m_axis_tuser[1]};
			if (pending_frame_bytes.size() == 0) begin
				errors++;
				$display("%0t: unexpected transfer, expected none, %s%h %s%b %s%b %s%b",
					$time, "actual data=", seen_byte.data, "start=", seen_byte.start,
					"end=", seen_byte.fend, "trunc=", seen_byte.trunc);
			end else begin
				want_byte = pending_frame_bytes.pop_front();
				if (seen_byte.data !== want_byte.data || seen_byte.start !== want_byte.start ||
						seen_byte.fend !== want_byte.fend || seen_byte.trunc !== want_byte.trunc) begin
					errors++;
					$display("%0t: mismatch, expected data=%h start=%b end=%b trunc=%b,",
						$time, want_byte.data, want_byte.start, want_byte.fend,
						want_byte.trunc);
					$display("%0t:   actual data=%h start=%b end=%b trunc=%b",
						$time, seen_byte.data, seen_byte.start, seen_byte.fend,
						seen_byte.trunc);
				end
			end
		end
	end

	function automatic void push_frame_byte(input logic [7:0] b, input logic st,
			input logic en, input logic tr);
		pending_frame_bytes.push_back('{data: b, start: st, fend: en, trunc: tr});
	endfunction

	// Predicts the frame bytes caused by one accepted input byte.
	function automatic void extract_frame_bytes(input logic [7:0] b, input logic last);
		int len;
		if (fr_in_frame) begin
			if (fr_left != 0)
				fr_left = fr_left - 12'd1;
			if (fr_left == 0) begin
				push_frame_byte(b, 1'b0, 1'b1, 1'b0);
				fr_in_frame = 1'b0;
			end else if (last) begin
				push_frame_byte(b, 1'b0, 1'b1, 1'b1);
				fr_in_frame = 1'b0;
				fr_left = '0;
			end else begin
				push_frame_byte(b, 1'b0, 1'b0, 1'b0);
			end
			fr_history = '0;
			fr_history_cnt = '0;
			framed_items++;
		end else if (fr_history_cnt >= 2 && fr_history == {SYNC_HI, SYNC_MID} && b == SYNC_HI) begin
			len = int'(fr_length);
			if (len < 3)
				len = 3;
			if (len > MAX_FRAME)
				len = MAX_FRAME;
			fr_history = '0;
			fr_history_cnt = '0;
			push_frame_byte(SYNC_HI, 1'b1, 1'b0, 1'b0);
			push_frame_byte(SYNC_MID, 1'b0, 1'b0, 1'b0);
			if (len == 3) begin
				push_frame_byte(SYNC_HI, 1'b0, 1'b1, 1'b0);
			end else if (last) begin
				push_frame_byte(SYNC_HI, 1'b0, 1'b1, 1'b1);
			end else begin
				push_frame_byte(SYNC_HI, 1'b0, 1'b0, 1'b0);
				fr_in_frame = 1'b1;
				fr_left = 12'(len - 3);
			end
			framed_items++;
		end else if (last) begin
			fr_history = '0;
			fr_history_cnt = '0;
		end else begin
			fr_history = {fr_history[7:0], b};
			if (fr_history_cnt < 2)
				fr_history_cnt = fr_history_cnt + 2'd1;
		end
	endfunction

	// Sends one byte; valid stays high into the next byte unless a gap is drawn.
	task automatic send_byte(input logic [7:0] b, input logic last);
		int gap;
		gap = 0;
		while ($urandom_range(99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tlast  <= last;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		extract_frame_bytes(b, last);
	endtask

	task automatic send_sync_word(input logic last);
		send_byte(SYNC_HI, 1'b0);
		send_byte(SYNC_MID, 1'b0);
		send_byte(SYNC_HI, last);
	endtask

	// Stops the input stream and waits until every predicted byte is out.
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (pending_frame_bytes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// The length register is written with no frame open, so an open frame is
	// closed by a datagram end first.
	task automatic set_frame_length(input logic [CFG_W-1:0] len);
		if (fr_in_frame)
			send_byte(8'($urandom_range(255)), 1'b1);
		settle();
		cfg_valid <= 1'b1;
		cfg_data  <= len;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		fr_length = len;
	endtask

	task automatic test_reset_length();
		send_sync_word(1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'hA5, 1'b1);
		settle();
	endtask

	task automatic test_short_lengths();
		// A length under three gives a frame of the sync word alone.
		set_frame_length(13'd0);
		send_sync_word(1'b0);
		send_byte(8'h33, 1'b1);
		// A sync word preceded by an extra high byte still matches.
		set_frame_length(13'd3);
		send_byte(SYNC_HI, 1'b0);
		send_sync_word(1'b1);
		settle();
	endtask

	task automatic test_sync_at_datagram_end();
		set_frame_length(13'd4);
		send_sync_word(1'b1);
		send_sync_word(1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h7E, 1'b1);
		settle();
	endtask

	task automatic test_history_cleared();
		send_byte(SYNC_HI, 1'b0);
		send_byte(SYNC_MID, 1'b1);
		send_byte(SYNC_HI, 1'b0);
		send_byte(8'h00, 1'b1);
		settle();
	endtask

	task automatic test_no_overlap();
		set_frame_length(13'd6);
		send_sync_word(1'b0);
		send_sync_word(1'b0);
		send_byte(SYNC_MID, 1'b0);
		send_byte(SYNC_HI, 1'b1);
		settle();
	endtask

	// The all-ones length clamps to the maximum; the long frame is then cut
	// short by a datagram end.
	task automatic test_length_extremes();
		set_frame_length(13'h1FFF);
		send_sync_word(1'b0);
		repeat (20)
			send_byte(8'($urandom_range(255)), 1'b0);
		send_byte(8'h5A, 1'b1);
		set_frame_length(13'(MAX_FRAME));
		send_sync_word(1'b0);
		send_byte(8'h11, 1'b0);
		send_byte(8'h22, 1'b1);
		settle();
	endtask

	// Datagrams mixing sync words, partial sync words and biased noise.
	task automatic send_random_datagram();
		int len;
		int pos;
		logic [7:0] b;
		len = ($urandom_range(9) == 0) ? $urandom_range(25, 60) : $urandom_range(1, 24);
		pos = 0;
		while (pos < len) begin
			if ($urandom_range(99) < 25 && pos + 3 <= len) begin
				send_sync_word(pos + 3 == len);
				pos += 3;
			end else begin
				case ($urandom_range(9))
					0, 1, 2: b = SYNC_HI;
					3, 4:    b = SYNC_MID;
					default: b = 8'($urandom_range(255));
				endcase
				send_byte(b, pos == len - 1);
				pos++;
			end
		end
	endtask

	task automatic test_random_traffic(input int send_pct, input int recv_pct, input int target);
		int goal;
		logic [CFG_W-1:0] len;
		send_idle_pct  = send_pct;
		recv_stall_pct = recv_pct;
		goal = framed_items + target;
		while (framed_items < goal) begin
			case ($urandom_range(9))
				0:       len = 13'($urandom_range(0, 2));
				1:       len = 13'($urandom_range(MAX_FRAME - 6, 8191));
				default: len = 13'($urandom_range(3, 16));
			endcase
			set_frame_length(len);
			repeat (3)
				send_random_datagram();
		end
		settle();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
	endtask

	initial begin
		fr_length      = FRAME_LEN_RESET;
		fr_in_frame    = 1'b0;
		fr_history     = '0;
		fr_history_cnt = '0;
		fr_left        = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_length();
		test_short_lengths();
		test_sync_at_datagram_end();
		test_history_cleared();
		test_no_overlap();
		test_length_extremes();
		test_random_traffic(0, 0, 40);
		test_random_traffic(65, 0, 40);
		test_random_traffic(0, 65, 40);
		test_random_traffic(8, 8, 40);

		settle();
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
